### rtl/core/gps_line_and_packet_framer_top_macros.svh
// Assertion macros shared by the checker of the GPS line and packet framer.
// Depends on nothing; included by the checker file.
`ifndef GPS_LINE_AND_PACKET_FRAMER_TOP_MACROS_SVH
`define GPS_LINE_AND_PACKET_FRAMER_TOP_MACROS_SVH

// Concurrent property that holds at every clock edge outside reset.
`define GPSF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("framer assertion failed");

// Implication from a condition to a consequence in the same cycle.
`define GPSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	`GPSF_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

### rtl/core/gpsf_pkg.sv
// Package of the GPS line and packet framer: sizes, byte codes and the result type.
// Depends on nothing; imported by every module of the block.
package gpsf_pkg;

	localparam int BUF_SIZE = 1024;
	localparam int POS_W = $clog2(BUF_SIZE);
	localparam int LEN_W = POS_W + 1;
	localparam int PLEN_W = 16;
	localparam int CMP_W = PLEN_W + 1;

	localparam logic [7:0] SYNC_BYTE = 8'hB5;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [POS_W-1:0] LEN_LO_OFFSET = POS_W'(4);
	localparam logic [POS_W-1:0] LEN_HI_OFFSET = POS_W'(5);
	localparam logic [CMP_W-1:0] PACKET_OVERHEAD = CMP_W'(8);

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [POS_W-1:0] byte_offset;
		logic             binary_frame;
		logic             frame_end;
		logic [LEN_W-1:0] frame_length;
		logic             overflow;
	} gpsf_result_t;

endpackage

### rtl/core/gpsf_in_reg.sv
// Input register of the framer: holds one received byte until the core takes it.
// Depends on gpsf_pkg.
module gpsf_in_reg
	import gpsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_data,
	output logic       valid_s1,
	output logic [7:0] data_s1,
	input  logic       take
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= rx_data;
		end
	end

endmodule

### rtl/core/gpsf_core.sv
// Framer core: frame state and the per-byte classification of the stream.
// Depends on gpsf_pkg.
module gpsf_core
	import gpsf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  logic [7:0]   data_s1,
	input  logic         space,
	output logic         take,
	output gpsf_result_t result
);

	logic [POS_W-1:0]  position_q;
	logic              in_binary_q;
	logic [PLEN_W-1:0] plen_q;

	logic              bin;
	logic [PLEN_W-1:0] plen_base;
	logic [PLEN_W-1:0] plen_next;
	logic [LEN_W-1:0]  next;
	logic              ovf;
	logic              end_text;
	logic              end_bin;
	logic              frame_done;

	assign take = valid_s1 && space;

	always_comb begin
		bin = (position_q == '0) ? (data_s1 == SYNC_BYTE) : in_binary_q;
		plen_base = (position_q == '0) ? '0 : plen_q;
		plen_next = plen_base;
		if (bin && position_q == LEN_LO_OFFSET) begin
			plen_next = {8'h00, data_s1};
		end else if (bin && position_q == LEN_HI_OFFSET) begin
			plen_next = {data_s1, plen_base[7:0]};
		end
		next = {1'b0, position_q} + LEN_W'(1);
		ovf = (next == LEN_W'(BUF_SIZE));
		end_text = !bin && (data_s1 == NEWLINE_BYTE);
		end_bin = bin && (CMP_W'(next) == ({1'b0, plen_next} + PACKET_OVERHEAD));
		frame_done = !ovf && (end_text || end_bin);

		result.data_byte = data_s1;
		result.byte_offset = position_q;
		result.binary_frame = bin;
		result.frame_end = frame_done;
		result.frame_length = frame_done ? next : '0;
		result.overflow = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			in_binary_q <= 1'b0;
			plen_q <= '0;
		end else if (take) begin
			in_binary_q <= bin;
			plen_q <= plen_next;
			if (ovf || frame_done) begin
				position_q <= '0;
			end else begin
				position_q <= next[POS_W-1:0];
			end
		end
	end

endmodule

### rtl/core/gpsf_out_reg.sv
// Result register of the framer: holds one result until the consumer takes it.
// Depends on gpsf_pkg.
module gpsf_out_reg
	import gpsf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  gpsf_result_t result,
	output logic         space,
	output logic         out_valid,
	input  logic         out_ready,
	output gpsf_result_t result_s2
);

	assign space = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (space) begin
			out_valid <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_s2 <= result;
		end
	end

endmodule

### rtl/core/gps_line_and_packet_framer_top.sv
// Top level of the GPS line and packet framer: input register, core and result register.
// Depends on gpsf_pkg, gpsf_in_reg, gpsf_core and gpsf_out_reg.
//
// The block takes one received byte per request and returns one result per byte,
// telling its offset in the current frame, whether the frame is a binary packet
// (first byte 0xB5, length at offsets 4 and 5) or a text line ending at a newline,
// and on the last byte the frame length; a frame that reaches the buffer size is
// flagged as overflow and restarts at offset 0. It sustains one byte per clock while
// the consumer accepts results (out_ready), because the core classifies each byte
// combinationally and updates the frame state as it takes the byte; a result passes
// through the input register and then the result register. There is no start-up pass after reset.
module gps_line_and_packet_framer_top
	import gpsf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       data_byte,
	output logic [POS_W-1:0] byte_offset,
	output logic             binary_frame,
	output logic             frame_end,
	output logic [LEN_W-1:0] frame_length,
	output logic             overflow
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         take;
	logic         space;
	gpsf_result_t result;
	gpsf_result_t result_s2;

	gpsf_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_data  (rx_data),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.take     (take)
	);

	gpsf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.space    (space),
		.take     (take),
		.result   (result)
	);

	gpsf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.result    (result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_s2 (result_s2)
	);

	assign data_byte = result_s2.data_byte;
	assign byte_offset = result_s2.byte_offset;
	assign binary_frame = result_s2.binary_frame;
	assign frame_end = result_s2.frame_end;
	assign frame_length = result_s2.frame_length;
	assign overflow = result_s2.overflow;

endmodule

### rtl/core/gpsf_checker.sv
// Port-level checker of the GPS line and packet framer and its bind to the top level.
// Depends on gpsf_pkg and gps_line_and_packet_framer_top_macros.svh.
`include "gps_line_and_packet_framer_top_macros.svh"

module gpsf_checker
	import gpsf_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [7:0]       rx_data,
	input logic             out_valid,
	input logic             out_ready,
	input logic [7:0]       data_byte,
	input logic [POS_W-1:0] byte_offset,
	input logic             binary_frame,
	input logic             frame_end,
	input logic [LEN_W-1:0] frame_length,
	input logic             overflow
);

	logic [POS_W-1:0] exp_off_q;

	// The offset that the next result must carry, from the results seen so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_off_q <= '0;
		end else if (out_valid && out_ready) begin
			if (frame_end || overflow) begin
				exp_off_q <= '0;
			end else begin
				exp_off_q <= byte_offset + POS_W'(1);
			end
		end
	end

	`GPSF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(byte_offset) && $stable(frame_end))
	`GPSF_ASSERT_IMP(a_offset_seq, clk, arst_n, out_valid, byte_offset == exp_off_q)
	`GPSF_ASSERT_IMP(a_length, clk, arst_n, out_valid, frame_end ? (!overflow && frame_length == ({1'b0, byte_offset} + LEN_W'(1))) : (frame_length == '0))
	`GPSF_ASSERT_IMP(a_overflow, clk, arst_n, out_valid, overflow == (byte_offset == POS_W'(BUF_SIZE - 1)))

endmodule

bind gps_line_and_packet_framer_top gpsf_checker u_gpsf_checker (.*);
